// ===== hdl/emx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emx_pkg: shared types and constants for the elevon mixer servo scaler
// Item structs, calibration struct, register indexes and pipeline depth.
// ----------------------------------------------------------------------------
package emx_pkg;

    // Command item: signed percentages
    typedef struct packed {
        logic signed [7:0] pitch_right;
        logic signed [7:0] pitch_left;
        logic signed [7:0] roll_cmd;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [15:0]       right_servo;
        logic [15:0]       left_servo;
        logic signed [7:0] right_mix;
        logic signed [7:0] left_mix;
    } t_result;

    // Calibration of one surface
    typedef struct packed {
        logic [15:0] neutral;
        logic [15:0] up_end;
        logic [15:0] down_end;
    } t_cal;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_R_NEUTRAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R_UP_END  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R_DOWN_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L_NEUTRAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L_UP_END  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L_DOWN_END = 3'd5;

    // Calibration after reset
    localparam t_cal CAL_RIGHT_RST = '{neutral: 16'd514, up_end: 16'd366, down_end: 16'd633};
    localparam t_cal CAL_LEFT_RST  = '{neutral: 16'd551, up_end: 16'd717, down_end: 16'd422};

    // Percent full scale
    localparam int unsigned PERCENT_SCALE = 100;

    // Register stages from command to result
    localparam int unsigned LANE_STAGES = 6;

endpackage : emx_pkg
`default_nettype wire

// ===== hdl/elevon_mixer_servo_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// elevon_mixer_servo_scaler: elevon mixer with calibrated servo scaling
// Mixes pitch and roll per surface and maps the result to servo counts.
// ----------------------------------------------------------------------------
// A command item is taken on every cycle that start is high; busy stays low,
// so one item per clock is sustained. Each item gives one result on o_result,
// flagged by o_valid for a single cycle, after one register stage each for
// mix, span select, multiply, reciprocal multiply, quotient correction and
// saturation. The result cannot be held off, so capture it on the strobe.
// Calibration registers are written through the cfg channel, which is
// always ready; write them only while no item is in flight. Indexes 6 and
// 7 are ignored.
module elevon_mixer_servo_scaler #(
    parameter int MIX_LIMIT = 100
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire emx_pkg::t_cmd                 i_cmd,
    output logic                               o_valid,
    output emx_pkg::t_result                   o_result,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [emx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data
);
    import emx_pkg::*;

    t_cal r_cal_right, n_cal_right;
    t_cal r_cal_left, n_cal_left;
    logic [LANE_STAGES-1:0] r_vld, n_vld;
    logic w_accept, w_cfg_we;

    // no stall anywhere: always ready for items and writes
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // calibration register writes
    always_comb begin
        n_cal_right = r_cal_right;
        n_cal_left  = r_cal_left;
        if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_R_NEUTRAL:  n_cal_right.neutral  = i_cfg_data;
                CFG_R_UP_END:   n_cal_right.up_end   = i_cfg_data;
                CFG_R_DOWN_END: n_cal_right.down_end = i_cfg_data;
                CFG_L_NEUTRAL:  n_cal_left.neutral   = i_cfg_data;
                CFG_L_UP_END:   n_cal_left.up_end    = i_cfg_data;
                CFG_L_DOWN_END: n_cal_left.down_end  = i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travel alongside the lane stages
    assign n_vld = {r_vld[LANE_STAGES-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_right <= CAL_RIGHT_RST;
            r_cal_left  <= CAL_LEFT_RST;
            r_vld       <= '0;
        end else begin
            r_cal_right <= n_cal_right;
            r_cal_left  <= n_cal_left;
            r_vld       <= n_vld;
        end
    end

    // right surface: pitch + roll
    emx_lane #(.MIX_LIMIT(MIX_LIMIT)) u_lane_right (
        .i_clk   (i_clk),
        .i_pitch (i_cmd.pitch_right),
        .i_roll  (i_cmd.roll_cmd),
        .i_sub   (1'b0),
        .i_cal   (r_cal_right),
        .o_servo (o_result.right_servo),
        .o_mix   (o_result.right_mix)
    );

    // left surface: pitch - roll
    emx_lane #(.MIX_LIMIT(MIX_LIMIT)) u_lane_left (
        .i_clk   (i_clk),
        .i_pitch (i_cmd.pitch_left),
        .i_roll  (i_cmd.roll_cmd),
        .i_sub   (1'b1),
        .i_cal   (r_cal_left),
        .o_servo (o_result.left_servo),
        .o_mix   (o_result.left_mix)
    );

    assign o_valid = r_vld[LANE_STAGES-1];

`ifndef ASSERT_OFF
    // every result comes from an item taken a fixed pipeline depth earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LANE_STAGES))
        else $error("result without a matching item");

    // a zero mix leaves the right servo at its neutral point
    a_zero_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MIX_LIMIT < 128) && o_valid && (o_result.right_mix == 8'sd0)
        |-> o_result.right_servo == $past(r_cal_right.neutral))
        else $error("right servo off neutral at zero mix");

    // a zero mix leaves the left servo at its neutral point
    a_zero_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MIX_LIMIT < 128) && o_valid && (o_result.left_mix == 8'sd0)
        |-> o_result.left_servo == $past(r_cal_left.neutral))
        else $error("left servo off neutral at zero mix");

    // mixed percentages stay within the limit
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MIX_LIMIT < 128) && o_valid
        |-> ($signed(o_result.right_mix) <= MIX_LIMIT)
            && ($signed(o_result.right_mix) >= -MIX_LIMIT)
            && ($signed(o_result.left_mix) <= MIX_LIMIT)
            && ($signed(o_result.left_mix) >= -MIX_LIMIT))
        else $error("mix out of range");
`endif

endmodule : elevon_mixer_servo_scaler
`default_nettype wire

// ===== hdl/emx_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emx_lane: mix and servo scaling pipeline for one surface
// Six register stages: mix, span select, multiply, reciprocal multiply,
// quotient correction, neutral offset and saturation.
// ----------------------------------------------------------------------------
module emx_lane #(
    parameter int MIX_LIMIT = 100
) (
    input  wire                       i_clk,
    input  wire logic signed [7:0]    i_pitch,
    input  wire logic signed [7:0]    i_roll,
    input  wire logic                 i_sub,
    input  wire emx_pkg::t_cal        i_cal,
    output logic [15:0]               o_servo,
    output logic signed [7:0]         o_mix
);
    import emx_pkg::*;

    localparam int LIM_W = $clog2(MIX_LIMIT + 1);
    localparam int MIX_W = ((LIM_W > 8) ? LIM_W : 8) + 2;
    localparam int P_W   = LIM_W + 16;
    localparam int K     = P_W + 6;
    localparam int Q_W   = P_W - 6;
    localparam int V_W   = ((Q_W > 16) ? Q_W : 16) + 2;

    localparam logic signed [MIX_W-1:0] LIM_P = MIX_W'(MIX_LIMIT);
    localparam logic signed [MIX_W-1:0] LIM_N = -LIM_P;
    // floor(2^K / 100): estimate is at most one below the true quotient
    localparam logic [P_W-1:0] RECIP = P_W'((64'd1 << K) / PERCENT_SCALE);
    localparam logic [P_W-1:0] SCALE = P_W'(PERCENT_SCALE);
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(65535);

    function automatic logic signed [MIX_W-1:0] clamp(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] r;
        if (v > LIM_P) begin
            r = LIM_P;
        end else if (v < LIM_N) begin
            r = LIM_N;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // stage 1: mix
    logic signed [MIX_W-1:0] r1_mix, n1_mix;
    logic signed [MIX_W-1:0] w_pitch, w_roll, w_sum;

    always_comb begin
        w_pitch = clamp(MIX_W'(i_pitch));
        w_roll  = MIX_W'(i_roll);
        w_sum   = i_sub ? (w_pitch - w_roll) : (w_pitch + w_roll);
        n1_mix  = clamp(w_sum);
    end

    always_ff @(posedge i_clk) begin
        r1_mix <= n1_mix;
    end

    // stage 2: magnitude and span toward the chosen end
    logic [LIM_W-1:0]  r2_mag, n2_mag;
    logic [15:0]       r2_span, n2_span;
    logic              r2_neg, n2_neg;
    logic [7:0]        r2_mix8;
    logic signed [MIX_W-1:0] w_abs;
    logic [15:0]       w_end;
    logic signed [16:0] w_diff;

    always_comb begin
        w_abs   = (r1_mix < 0) ? -r1_mix : r1_mix;
        n2_mag  = LIM_W'(w_abs);
        w_end   = (r1_mix > 0) ? i_cal.up_end : i_cal.down_end;
        w_diff  = $signed({1'b0, w_end}) - $signed({1'b0, i_cal.neutral});
        n2_neg  = w_diff[16];
        n2_span = n2_neg ? 16'(-w_diff) : w_diff[15:0];
    end

    always_ff @(posedge i_clk) begin
        r2_mag  <= n2_mag;
        r2_span <= n2_span;
        r2_neg  <= n2_neg;
        r2_mix8 <= r1_mix[7:0];
    end

    // stage 3: |mix| * |span|
    logic [P_W-1:0] r3_prod;
    logic           r3_neg;
    logic [7:0]     r3_mix8;

    always_ff @(posedge i_clk) begin
        r3_prod <= P_W'(r2_mag) * P_W'(r2_span);
        r3_neg  <= r2_neg;
        r3_mix8 <= r2_mix8;
    end

    // stage 4: quotient estimate by reciprocal multiply
    logic [2*P_W-1:0] w_rp;
    logic [Q_W-1:0]   r4_qe;
    logic [P_W-1:0]   r4_prod;
    logic             r4_neg;
    logic [7:0]       r4_mix8;

    assign w_rp = (2*P_W)'(r3_prod) * (2*P_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        r4_qe   <= w_rp[K +: Q_W];
        r4_prod <= r3_prod;
        r4_neg  <= r3_neg;
        r4_mix8 <= r3_mix8;
    end

    // stage 5: correct estimate by one step
    logic [Q_W-1:0] r5_q, n5_q;
    logic [P_W-1:0] w_rem;
    logic           r5_neg;
    logic [7:0]     r5_mix8;

    always_comb begin
        w_rem = r4_prod - P_W'(r4_qe) * SCALE;
        n5_q  = (w_rem >= SCALE) ? (r4_qe + Q_W'(1)) : r4_qe;
    end

    always_ff @(posedge i_clk) begin
        r5_q    <= n5_q;
        r5_neg  <= r4_neg;
        r5_mix8 <= r4_mix8;
    end

    // stage 6: offset from neutral, saturate to 0..65535
    logic [15:0]           r6_servo, n6_servo;
    logic [7:0]            r6_mix8;
    logic signed [V_W-1:0] w_val, w_neu, w_off;

    always_comb begin
        w_neu = V_W'($signed({1'b0, i_cal.neutral}));
        w_off = V_W'($signed({1'b0, r5_q}));
        w_val = r5_neg ? (w_neu - w_off) : (w_neu + w_off);
        if (w_val < 0) begin
            n6_servo = 16'd0;
        end else if (w_val > SAT_HI) begin
            n6_servo = 16'hFFFF;
        end else begin
            n6_servo = w_val[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r6_servo <= n6_servo;
        r6_mix8  <= r5_mix8;
    end

    assign o_servo = r6_servo;
    assign o_mix   = $signed(r6_mix8);

endmodule : emx_lane
`default_nettype wire

// ===== sim/elevon_mixer_servo_scaler_tb.sv =====
// ----------------------------------------------------------------------------
// elevon_mixer_servo_scaler_tb: self-checking bench for the elevon mixer
// Feeds command items through the start/busy port with random gaps, predicts
// the mixed percentages and servo counts in the bench and checks every strobed
// result against them, in order. It steps through several calibrations,
// including all-zero, all-ones and inverted spans.
// ----------------------------------------------------------------------------
module elevon_mixer_servo_scaler_tb;
    import emx_pkg::*;

    localparam int MIX_LIM        = 100;
    localparam int RAND_PER_PHASE = 50;
    localparam int N_PHASES       = 9;
    localparam int MAX_REPORTS    = 10;

    // Unmapped register indexes, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_cmd                 cmd = '0;
    logic                 res_valid;
    t_result              res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    // Bench copy of the calibration
    t_cal cal_r = CAL_RIGHT_RST;
    t_cal cal_l = CAL_LEFT_RST;

    t_cmd    cmd_pending[$];
    t_result servo_expected[$];

    int gap_left = 0;
    bit no_idle = 1'b0;
    int n_sent = 0;
    int n_checked = 0;
    int n_err = 0;

    elevon_mixer_servo_scaler #(
        .MIX_LIMIT(MIX_LIM)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (cmd),
        .o_valid    (res_valid),
        .o_result   (res),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int hold_pct(input int v);
        if (v > MIX_LIM) return MIX_LIM;
        if (v < -MIX_LIM) return -MIX_LIM;
        return v;
    endfunction

    // Map a mixed percentage onto the surface's calibrated travel
    function automatic logic [15:0] servo_count(input int m, input t_cal cal);
        longint span;
        longint mag;
        longint pct;
        longint val;
        pct = PERCENT_SCALE;
        if (m == 0) return cal.neutral;
        span = (m > 0) ? longint'(cal.up_end) - longint'(cal.neutral)
                       : longint'(cal.down_end) - longint'(cal.neutral);
        mag = (m > 0) ? longint'(m) : -longint'(m);
        // offset truncated toward zero in both directions
        if (span >= 0)
            val = longint'(cal.neutral) + (mag * span) / pct;
        else
            val = longint'(cal.neutral) - (mag * (-span)) / pct;
        if (val < 0) val = 0;
        if (val > 65535) val = 65535;
        return val[15:0];
    endfunction

    function automatic t_result predict_surfaces(input t_cmd c, input t_cal rc,
                                                 input t_cal lc);
        t_result r;
        int      rm;
        int      lm;
        rm = hold_pct(hold_pct(int'($signed(c.pitch_right))) + int'($signed(c.roll_cmd)));
        lm = hold_pct(hold_pct(int'($signed(c.pitch_left))) - int'($signed(c.roll_cmd)));
        r.right_servo = servo_count(rm, rc);
        r.left_servo  = servo_count(lm, lc);
        r.right_mix   = rm[7:0];
        r.left_mix    = lm[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_cmd make_cmd(input int pr, input int pl, input int roll);
        t_cmd c;
        c.pitch_right = pr[7:0];
        c.pitch_left  = pl[7:0];
        c.roll_cmd    = roll[7:0];
        return c;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0: return -128;
            1: return -100;
            2: return 100;
            default: return 127;
        endcase
    endfunction

    // Mostly in-range commands, some cancelling to zero mix, some at the rails
    function automatic t_cmd random_cmd();
        int roll;
        case ($urandom_range(0, 9))
            0: return make_cmd($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
            1: begin
                roll = $urandom_range(0, 200) - 100;
                return make_cmd(-roll, roll, roll);
            end
            2: return make_cmd(pick_extreme(), pick_extreme(), pick_extreme());
            default: return make_cmd($urandom_range(0, 200) - 100,
                                     $urandom_range(0, 200) - 100,
                                     $urandom_range(0, 200) - 100);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: one item per start/busy handshake, random gaps between
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                servo_expected.push_back(predict_surfaces(cmd, cal_r, cal_l));
                n_sent = n_sent + 1;
            end
            if (!(start && busy)) begin
                if (gap_left != 0) begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (cmd_pending.size() != 0) begin
                    cmd   <= cmd_pending.pop_front();
                    start <= 1'b1;
                    // switch between idle-free bursts and gappy stretches
                    if ($urandom_range(0, 31) == 0) no_idle = ~no_idle;
                    gap_left <= no_idle ? 0 : $urandom_range(0, 14);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each strobed item with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_valid) begin
            if (servo_expected.size() == 0) begin
                n_err = n_err + 1;
                if (n_err <= MAX_REPORTS)
                    $display("%0t: unexpected result rs=%0d ls=%0d rm=%0d lm=%0d",
                             $realtime, res.right_servo, res.left_servo,
                             res.right_mix, res.left_mix);
            end else begin
                want = servo_expected.pop_front();
                n_checked = n_checked + 1;
                if (res.right_servo !== want.right_servo ||
                    res.left_servo  !== want.left_servo  ||
                    res.right_mix   !== want.right_mix   ||
                    res.left_mix    !== want.left_mix) begin
                    n_err = n_err + 1;
                    if (n_err <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp rs=%0d ls=%0d rm=%0d lm=%0d",
                                 $realtime, want.right_servo, want.left_servo,
                                 want.right_mix, want.left_mix);
                        $display("%0t:          got rs=%0d ls=%0d rm=%0d lm=%0d",
                                 $realtime, res.right_servo, res.left_servo,
                                 res.right_mix, res.left_mix);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Configuration writes, only called while the pipeline is empty
    // ------------------------------------------------------------------------
    // Leaves valid high; the caller lowers it after the last write
    task automatic write_cal_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_R_NEUTRAL:  cal_r.neutral  = data;
            CFG_R_UP_END:   cal_r.up_end   = data;
            CFG_R_DOWN_END: cal_r.down_end = data;
            CFG_L_NEUTRAL:  cal_l.neutral  = data;
            CFG_L_UP_END:   cal_l.up_end   = data;
            CFG_L_DOWN_END: cal_l.down_end = data;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input t_cal rc, input t_cal lc);
        write_cal_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      $urandom_range(0, 65535));
        write_cal_reg(CFG_R_NEUTRAL,  rc.neutral);
        write_cal_reg(CFG_R_UP_END,   rc.up_end);
        write_cal_reg(CFG_R_DOWN_END, rc.down_end);
        write_cal_reg(CFG_L_NEUTRAL,  lc.neutral);
        write_cal_reg(CFG_L_UP_END,   lc.up_end);
        write_cal_reg(CFG_L_DOWN_END, lc.down_end);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the driver and the pipeline to empty, then let it settle
    task automatic wait_drained();
        @(posedge clk);
        while (cmd_pending.size() != 0 || start || servo_expected.size() != 0)
            @(posedge clk);
        repeat (LANE_STAGES + 2) @(posedge clk);
    endtask

    function automatic t_cal rand_cal();
        t_cal c;
        c.neutral  = $urandom_range(0, 65535);
        c.up_end   = $urandom_range(0, 65535);
        c.down_end = $urandom_range(0, 65535);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Sequence: reset, directed items, then random items per calibration
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: load_calibration('{16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0});
                    2: load_calibration('{16'hFFFF, 16'hFFFF, 16'hFFFF},
                                        '{16'hFFFF, 16'hFFFF, 16'hFFFF});
                    3: load_calibration('{16'd0, 16'hFFFF, 16'hFFFF},
                                        '{16'd0, 16'hFFFF, 16'hFFFF});
                    4: load_calibration('{16'hFFFF, 16'd0, 16'd0},
                                        '{16'hFFFF, 16'd0, 16'd0});
                    5: load_calibration('{16'd32768, 16'd0, 16'hFFFF},
                                        '{16'd100, 16'hFFFF, 16'd0});
                    default: load_calibration(rand_cal(), rand_cal());
                endcase
            end

            if (ph == 0) begin
                // zero mix, full travel, rails and cancellation
                cmd_pending.push_back(make_cmd(0, 0, 0));
                cmd_pending.push_back(make_cmd(100, 100, 0));
                cmd_pending.push_back(make_cmd(-100, -100, 0));
                cmd_pending.push_back(make_cmd(127, 127, 127));
                cmd_pending.push_back(make_cmd(-128, -128, -128));
                cmd_pending.push_back(make_cmd(127, -128, 0));
                cmd_pending.push_back(make_cmd(100, -100, 100));
                cmd_pending.push_back(make_cmd(-100, 100, -100));
                cmd_pending.push_back(make_cmd(50, -50, 50));
                cmd_pending.push_back(make_cmd(-30, 30, 30));
                cmd_pending.push_back(make_cmd(1, 1, 0));
                cmd_pending.push_back(make_cmd(-1, -1, 0));
                cmd_pending.push_back(make_cmd(0, 0, 1));
                cmd_pending.push_back(make_cmd(0, 0, -1));
                cmd_pending.push_back(make_cmd(99, -99, 1));
                cmd_pending.push_back(make_cmd(-99, 99, -1));
                cmd_pending.push_back(make_cmd(60, 60, 60));
                cmd_pending.push_back(make_cmd(85, -86, -86));
                cmd_pending.push_back(make_cmd(-86, 85, 85));
                cmd_pending.push_back(make_cmd(-128, 127, 127));
            end
            repeat (RAND_PER_PHASE) cmd_pending.push_back(random_cmd());
        end

        wait_drained();
        if (servo_expected.size() != 0) begin
            n_err = n_err + servo_expected.size();
            $display("%0d predicted results never arrived", servo_expected.size());
        end
        $display("Drove %0d command items across %0d calibrations, checked %0d results",
                 n_sent, N_PHASES, n_checked);
        $display("Calibrations took in zero, full-scale and inverted spans on both sides");
        if (n_err == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
